// File: rtl/rlepm_pkg.sv
// Package for the run-length encoded pair merge reducer.
// Holds the sizing constants, operation codes, transaction payload types and state type.
// Depends on nothing; every RTL file of the block imports it.
package rlepm_pkg;

   localparam int unsigned MAX_RUNS = 1024;
   localparam int unsigned POS_BITS = 24;

   localparam int unsigned IDX_W = $clog2(MAX_RUNS);
   localparam int unsigned CNT_W = $clog2(MAX_RUNS + 1);
   localparam int unsigned END_W = (POS_BITS < 24) ? POS_BITS : 24;
   localparam int unsigned LEN_W = 25;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned ACC_W = 64;
   localparam int unsigned ENT_W = VAL_W + END_W;

   typedef logic [1:0] op_type;

   localparam op_type OP_LOAD_A = 2'd0;
   localparam op_type OP_LOAD_B = 2'd1;
   localparam op_type OP_PROD   = 2'd2;
   localparam op_type OP_COUNT  = 2'd3;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] run_value;
      logic [23:0]        run_end;
      logic [24:0]        total_length;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               saturated;
      logic               runs_exhausted;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEG,
      ST_MUL_P,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SCALE,
      ST_ACCUM,
      ST_DONE
   } state_type;

endpackage

// File: rtl/rle_pair_merge_reducer.sv
// Top level of the run-length encoded pair merge reducer: run stores, merge sequencer,
// shared 32x32 multiplier and saturating accumulator.
// Depends on rlepm_pkg.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | rlepm_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | rlepm_pkg::rsp_type
//
// A load transaction leaves the sequencer idle. A compute transaction takes each merged segment
// through CHECK, SEG and ACCUM, with MUL_P, MUL_LO, MUL_HI and SCALE before ACCUM in product mode;
// a skipped backward run passes CHECK and SEG, and the walk ends with CHECK and DONE.
// Reset empties both run stores by clearing their fill counts; the store memories are not cleared.
// A result waits in the output register while rsp_stall is high; req_stall is high while
// a compute transaction is in progress or its result cannot yet be placed.
module rle_pair_merge_reducer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rlepm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rlepm_pkg::rsp_type rsp_data
);
   import rlepm_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CNT_W-1:0] i1_ff, i1_in, i2_ff, i2_in;
   logic [LEN_W-1:0] k_ff, k_in, len_ff, len_in, cnt_ff, cnt_in;
   logic             prod_ff, prod_in, sat_ff, sat_in, exh_ff, exh_in;
   logic             neg_ff, neg_in, clip_ff, clip_in;
   logic [VAL_W-1:0] abs_a_ff, abs_a_in, abs_b_ff, abs_b_in;
   logic [31:0]      mag_ff, mag_in;
   logic [63:0]      plo_ff, plo_in, mul_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, term_ff, term_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [ENT_W-1:0] mem_a [MAX_RUNS];
   logic [ENT_W-1:0] mem_b [MAX_RUNS];
   logic [ENT_W-1:0] rd_a_ff, rd_b_ff;

   logic [31:0]      mul_x, mul_y;
   logic             req_accept, is_compute, load_a_we, load_b_we, out_free;
   logic             exhausted, walk_done;
   logic [END_W-1:0] ea, eb;
   logic [LEN_W-1:0] ea_ext, eb_ext, e_ext, next_pos, next_cl, seg_cnt;
   logic signed [VAL_W-1:0] va, vb;
   logic             a_behind, b_behind;
   logic [95:0]      full_mag, lim_mag;
   logic [63:0]      term_mag;
   logic             scale_clip;
   logic signed [ACC_W:0] sum_ext;

   assign req_accept = req_valid & ~req_stall;
   assign is_compute = (req_data.op == OP_PROD) || (req_data.op == OP_COUNT);
   assign load_a_we  = req_accept && (req_data.op == OP_LOAD_A)
                       && (count_a_ff < CNT_W'(MAX_RUNS));
   assign load_b_we  = req_accept && (req_data.op == OP_LOAD_B)
                       && (count_b_ff < CNT_W'(MAX_RUNS));
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign exhausted  = (i1_ff >= count_a_ff) || (i2_ff >= count_b_ff);
   assign walk_done  = (k_ff >= len_ff);

   assign ea       = rd_a_ff[END_W-1:0];
   assign eb       = rd_b_ff[END_W-1:0];
   assign va       = rd_a_ff[ENT_W-1:END_W];
   assign vb       = rd_b_ff[ENT_W-1:END_W];
   assign ea_ext   = LEN_W'(ea);
   assign eb_ext   = LEN_W'(eb);
   assign a_behind = ea_ext < k_ff;
   assign b_behind = eb_ext < k_ff;
   assign e_ext    = (ea_ext < eb_ext) ? ea_ext : eb_ext;
   assign next_pos = e_ext + LEN_W'(1);
   assign next_cl  = (next_pos > len_ff) ? len_ff : next_pos;
   assign seg_cnt  = next_cl - k_ff;

   assign full_mag   = {mul_ff, 32'd0} + {32'd0, plo_ff};
   assign lim_mag    = neg_ff ? {32'd0, 1'b1, 63'd0} : {33'd0, {63{1'b1}}};
   assign scale_clip = full_mag > lim_mag;
   assign term_mag   = scale_clip ? lim_mag[63:0] : full_mag[63:0];
   assign sum_ext    = {acc_ff[ACC_W-1], acc_ff} + {term_ff[ACC_W-1], term_ff};

   always_ff @(posedge clock) begin
      if (load_a_we) begin
         mem_a[count_a_ff[IDX_W-1:0]] <= {req_data.run_value, req_data.run_end[END_W-1:0]};
      end
      if (load_b_we) begin
         mem_b[count_b_ff[IDX_W-1:0]] <= {req_data.run_value, req_data.run_end[END_W-1:0]};
      end
      rd_a_ff <= mem_a[i1_ff[IDX_W-1:0]];
      rd_b_ff <= mem_b[i2_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_compute) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (walk_done || exhausted) state_in = ST_DONE;
            else state_in = ST_SEG;
         end
         ST_SEG: begin
            if (a_behind || b_behind) state_in = ST_CHECK;
            else if (prod_ff) state_in = ST_MUL_P;
            else state_in = ST_ACCUM;
         end
         ST_MUL_P:  state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_CHECK;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
      mul_x     = '0;
      mul_y     = '0;
      case (state_ff)
         ST_MUL_P: begin
            mul_x = abs_a_ff;
            mul_y = abs_b_ff;
         end
         ST_MUL_LO: begin
            mul_x = mul_ff[31:0];
            mul_y = 32'(cnt_ff);
         end
         ST_MUL_HI: begin
            mul_x = mag_ff;
            mul_y = 32'(cnt_ff);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   always_comb begin
      count_a_in   = load_a_we ? count_a_ff + CNT_W'(1) : count_a_ff;
      count_b_in   = load_b_we ? count_b_ff + CNT_W'(1) : count_b_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      sat_in       = sat_ff;
      exh_in       = exh_ff;
      neg_in       = neg_ff;
      clip_in      = clip_ff;
      abs_a_in     = abs_a_ff;
      abs_b_in     = abs_b_ff;
      mag_in       = mag_ff;
      plo_in       = plo_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_compute) begin
               i1_in   = '0;
               i2_in   = '0;
               k_in    = '0;
               acc_in  = '0;
               sat_in  = 1'b0;
               exh_in  = 1'b0;
               len_in  = req_data.total_length;
               prod_in = (req_data.op == OP_PROD);
            end
         end
         ST_CHECK: begin
            if (!walk_done && exhausted) exh_in = 1'b1;
         end
         ST_SEG: begin
            if (a_behind) begin
               i1_in = i1_ff + CNT_W'(1);
            end else if (b_behind) begin
               i2_in = i2_ff + CNT_W'(1);
            end else begin
               cnt_in   = seg_cnt;
               abs_a_in = va[VAL_W-1] ? VAL_W'(-va) : VAL_W'(va);
               abs_b_in = vb[VAL_W-1] ? VAL_W'(-vb) : VAL_W'(vb);
               neg_in   = va[VAL_W-1] ^ vb[VAL_W-1];
               clip_in  = 1'b0;
               term_in  = ((va != '0) || (vb != '0)) ? ACC_W'(seg_cnt) : '0;
               k_in     = next_cl;
               if (ea_ext == e_ext) i1_in = i1_ff + CNT_W'(1);
               if (eb_ext == e_ext) i2_in = i2_ff + CNT_W'(1);
            end
         end
         ST_MUL_LO: mag_in = mul_ff[63:32];
         ST_MUL_HI: plo_in = mul_ff;
         ST_SCALE: begin
            clip_in = scale_clip;
            term_in = neg_ff ? -$signed(term_mag) : $signed(term_mag);
         end
         ST_ACCUM: begin
            if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
               acc_in = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
               sat_in = 1'b1;
            end else begin
               acc_in = sum_ext[ACC_W-1:0];
               sat_in = sat_ff | clip_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_value    = acc_ff;
               rsp_data_in.saturated       = sat_ff;
               rsp_data_in.runs_exhausted  = exh_ff;
            end
         end
         default: begin
            i1_in = i1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      k_ff        <= k_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      sat_ff      <= sat_in;
      exh_ff      <= exh_in;
      neg_ff      <= neg_in;
      clip_ff     <= clip_in;
      abs_a_ff    <= abs_a_in;
      abs_b_ff    <= abs_b_in;
      mag_ff      <= mag_in;
      plo_ff      <= plo_in;
      acc_ff      <= acc_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
      mul_ff      <= {32'd0, mul_x} * {32'd0, mul_y};
   end

   // A new result appears only when the sequencer has finished a compute transaction.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");

   // Run stores never hold more than their capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_W'(MAX_RUNS)) && (count_b_ff <= CNT_W'(MAX_RUNS)))
      else $error("run store fill count beyond capacity");

   // A segment is only evaluated on runs that were loaded.
   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG) |-> (i1_ff < count_a_ff) && (i2_ff < count_b_ff))
      else $error("segment read beyond loaded runs");

   // The walk position never passes the requested length.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && $past(state_ff != ST_IDLE) |-> (k_ff <= len_ff))
      else $error("walk position beyond total length");

   // Count mode never reports saturation.
   a_count_no_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && !prod_ff |-> !sat_ff)
      else $error("saturation flagged in count mode");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rle_pair_merge_reducer: a directed table, then random run loads
// and reductions, each checked against a table outcome or a behavioural merge of both run stores.
// Depends on rlepm_pkg and the rle_pair_merge_reducer RTL.
module testbench;

   import rlepm_pkg::*;

   localparam int unsigned N_DIRECTED     = 25;
   localparam int unsigned N_RANDOM       = 1500;
   localparam int unsigned HOLD_AT        = 400;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned EXTRA_LOADS    = 6;
   localparam int unsigned DRAIN_CYCLES   = 64;
   localparam int unsigned WATCHDOG_LIMIT = 100000;

   localparam logic signed [127:0] ACC_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] ACC_LO = -ACC_HI - 128'sd1;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [23:0]        run_end;
      logic [24:0]        length;
      logic               typed;
      rsp_type            outcome;
   } table_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   localparam table_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'd5,          1'b1,
        '{64'sd0, 1'b0, 1'b1}},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'd0,          1'b1,
        '{64'sd0, 1'b0, 1'b0}},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'h100_0000,   1'b1,
        '{64'sd0, 1'b0, 1'b1}},
      '{OP_LOAD_A,  32'h7FFF_FFFF, 24'd3,        25'd0,          1'b0, '0},
      '{OP_LOAD_B,  32'h7FFF_FFFF, 24'd3,        25'd0,          1'b0, '0},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'd1,          1'b1,
        '{64'sh3FFF_FFFF_0000_0001, 1'b0, 1'b0}},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'd4,          1'b1,
        '{64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
      '{OP_LOAD_A,  32'h8000_0000, 24'd7,        25'd0,          1'b0, '0},
      '{OP_LOAD_B,  32'h7FFF_FFFF, 24'd7,        25'd0,          1'b0, '0},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'd8,          1'b0, '0},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'd8,          1'b0, '0},
      '{OP_LOAD_A,  32'h0000_0000, 24'd9,        25'd0,          1'b0, '0},
      '{OP_LOAD_B,  32'h0000_0000, 24'd11,       25'd0,          1'b0, '0},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'd12,         1'b0, '0},
      '{OP_LOAD_A,  32'h0005_0000, 24'd2,        25'd0,          1'b0, '0},
      '{OP_LOAD_A,  32'h0001_0000, 24'd20,       25'd0,          1'b0, '0},
      '{OP_LOAD_B,  32'hFFFD_0000, 24'd20,       25'd0,          1'b0, '0},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'd21,         1'b0, '0},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'd21,         1'b0, '0},
      '{OP_LOAD_A,  32'h8000_0000, 24'hFF_FFFF,  25'd0,          1'b0, '0},
      '{OP_LOAD_B,  32'h8000_0000, 24'hFF_FFFF,  25'd0,          1'b0, '0},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'h100_0000,   1'b0, '0},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'h100_0000,   1'b0, '0},
      '{OP_PROD,    32'h0000_0000, 24'd0,        25'h1FF_FFFF,   1'b0, '0},
      '{OP_COUNT,   32'h0000_0000, 24'd0,        25'h1FF_FFFF,   1'b0, '0}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic signed [31:0] a_val [MAX_RUNS];
   logic [23:0]        a_end [MAX_RUNS];
   logic signed [31:0] b_val [MAX_RUNS];
   logic [23:0]        b_end [MAX_RUNS];
   int unsigned        a_count = 0;
   int unsigned        b_count = 0;
   logic [24:0]        a_front = '0;
   logic [24:0]        b_front = '0;

   rsp_type     reduction_queue [$];
   logic        hold_ask      = 1'b0;
   int unsigned burst_left    = 0;
   int unsigned loads_seen    = 0;
   int unsigned loads_dropped = 0;
   int unsigned reductions    = 0;
   int unsigned sat_seen      = 0;
   int unsigned exh_seen      = 0;
   int unsigned error_count   = 0;

   rle_pair_merge_reducer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic void store_run(input req_type r);
      loads_seen++;
      if (r.op == OP_LOAD_A) begin
         if (a_count < MAX_RUNS) begin
            a_val[a_count] = r.run_value;
            a_end[a_count] = r.run_end;
            a_count++;
            if (25'(r.run_end) + 25'd1 > a_front) a_front = 25'(r.run_end) + 25'd1;
         end else begin
            loads_dropped++;
         end
      end else begin
         if (b_count < MAX_RUNS) begin
            b_val[b_count] = r.run_value;
            b_end[b_count] = r.run_end;
            b_count++;
            if (25'(r.run_end) + 25'd1 > b_front) b_front = 25'(r.run_end) + 25'd1;
         end else begin
            loads_dropped++;
         end
      end
   endfunction

   function automatic rsp_type merge_reduce(input req_type r);
      rsp_type             res;
      logic [63:0]         k, len, ea, eb, e, nxt, cnt;
      int unsigned         ia, ib;
      logic signed [127:0] acc, prod, term;
      logic                sat, exh;
      k = '0;
      len = 64'(r.total_length);
      ia = 0;
      ib = 0;
      acc = '0;
      sat = 1'b0;
      exh = 1'b0;
      while (k < len) begin
         if (ia >= a_count || ib >= b_count) begin
            exh = 1'b1;
            break;
         end
         ea = 64'(a_end[ia]);
         eb = 64'(b_end[ib]);
         if (ea < k) begin
            ia++;
            continue;
         end
         if (eb < k) begin
            ib++;
            continue;
         end
         e = (ea < eb) ? ea : eb;
         nxt = (e + 64'd1 > len) ? len : e + 64'd1;
         cnt = nxt - k;
         if (r.op == OP_PROD) begin
            prod = 128'(a_val[ia]) * 128'(b_val[ib]);
            term = prod * $signed({64'd0, cnt});
            if (term > ACC_HI) begin
               term = ACC_HI;
               sat = 1'b1;
            end else if (term < ACC_LO) begin
               term = ACC_LO;
               sat = 1'b1;
            end
            acc = acc + term;
            if (acc > ACC_HI) begin
               acc = ACC_HI;
               sat = 1'b1;
            end else if (acc < ACC_LO) begin
               acc = ACC_LO;
               sat = 1'b1;
            end
         end else if (a_val[ia] != 0 || b_val[ib] != 0) begin
            acc = acc + $signed({64'd0, cnt});
         end
         if (ea == e) ia++;
         if (eb == e) ib++;
         k = nxt;
      end
      res.result_value   = acc[63:0];
      res.saturated      = sat;
      res.runs_exhausted = exh;
      return res;
   endfunction

   function automatic logic signed [31:0] pick_run_value();
      case ($urandom_range(0, 9))
         0, 1:    return 32'sd0;
         2:       return 32'sh7FFF_FFFF;
         3:       return 32'h8000_0000;
         4, 5:    return 32'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic logic [24:0] near_run_end(input int unsigned span);
      int unsigned fill, idx;
      logic [23:0] e;
      logic        use_a;
      use_a = 1'($urandom_range(0, 1));
      fill = use_a ? a_count : b_count;
      if (fill == 0) return 25'($urandom_range(1, 16));
      idx = $urandom_range(0, ((fill < span) ? fill : span) - 1);
      e = use_a ? a_end[idx] : b_end[idx];
      return 25'(e) + 25'($urandom_range(0, 2));
   endfunction

   function automatic req_type make_load_req(input op_type op);
      req_type     r;
      int unsigned sel;
      logic [24:0] front;
      front = (op == OP_LOAD_A) ? a_front : b_front;
      r.op = op;
      r.run_value = pick_run_value();
      r.total_length = 25'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 82) begin
         r.run_end = 24'(front + 25'($urandom_range(0, 15)));
      end else if (sel < 91) begin
         r.run_end = 24'(front + 25'($urandom_range(16, 2000)));
      end else if (sel < 92) begin
         r.run_end = 24'(front + 25'($urandom_range(2001, 1 << 18)));
      end else if (front == 0) begin
         r.run_end = '0;
      end else begin
         r.run_end = 24'(front - 25'($urandom_range(1, (front < 40) ? front : 40)));
      end
      return r;
   endfunction

   function automatic req_type make_compute_req();
      req_type     r;
      int unsigned sel;
      logic [24:0] reach;
      r.op = ($urandom_range(0, 9) < 6) ? OP_PROD : OP_COUNT;
      r.run_value = 32'($urandom);
      r.run_end = 24'($urandom);
      reach = (a_front > b_front) ? a_front : b_front;
      sel = $urandom_range(0, 99);
      if (sel < 65) r.total_length = near_run_end(32);
      else if (sel < 80) r.total_length = near_run_end(MAX_RUNS);
      else if (sel < 92) r.total_length = 25'($urandom_range(0, 64));
      else if (sel < 97) r.total_length = reach + 25'($urandom_range(0, 100));
      else r.total_length = 25'($urandom);
      return r;
   endfunction

   function automatic req_type make_random_req();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return make_load_req(OP_LOAD_A);
      if (sel < 83) return make_load_req(OP_LOAD_B);
      return make_compute_req();
   endfunction

   task automatic offer(input req_type item, input logic typed, input rsp_type outcome);
      int unsigned gap;
      rsp_type     due;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (item.op == OP_LOAD_A || item.op == OP_LOAD_B) begin
         store_run(item);
      end else begin
         due = typed ? outcome : merge_reduce(item);
         reduction_queue.push_back(due);
         reductions++;
         if (due.saturated) sat_seen++;
         if (due.runs_exhausted) exh_seen++;
      end
   endtask

   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : result_side
      stall_mode_type mode;
      int unsigned    span_left, hold_left, tick;
      logic           stall_next;
      rsp_stall = 1'b0;
      mode = STALL_NONE;
      span_left = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = LONG_HOLD - 1;
            stall_next = 1'b1;
         end else begin
            if (span_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               span_left = $urandom_range(8, 120);
            end
            span_left--;
            case (mode)
               STALL_NONE:   stall_next = 1'b0;
               STALL_SPARSE: stall_next = ($urandom_range(0, 7) == 0);
               STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
               default:      stall_next = ((tick % 7) < 3);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin : result_check
      rsp_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (reduction_queue.size() == 0) begin
               $error("result transaction with none outstanding: result_value %0d",
                      rsp_data.result_value);
               error_count++;
            end else begin
               want = reduction_queue.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.result_value, rsp_data.result_value);
                  error_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b",
                         want.saturated, rsp_data.saturated);
                  error_count++;
               end
               if (rsp_data.runs_exhausted !== want.runs_exhausted) begin
                  $error("runs_exhausted: expected %0b, got %0b",
                         want.runs_exhausted, rsp_data.runs_exhausted);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_type     item;
      int unsigned n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < N_DIRECTED; n++) begin
         item.op           = DIRECTED_ROWS[n].op;
         item.run_value    = DIRECTED_ROWS[n].value;
         item.run_end      = DIRECTED_ROWS[n].run_end;
         item.total_length = DIRECTED_ROWS[n].length;
         offer(item, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].outcome);
      end

      for (n = 0; n < N_RANDOM; n++) begin
         if (n == HOLD_AT) hold_ask = 1'b1;
         offer(make_random_req(), 1'b0, '0);
      end

      while (a_count < MAX_RUNS) begin
         offer(make_load_req(OP_LOAD_A), 1'b0, '0);
         if ($urandom_range(0, 3) == 0) offer(make_load_req(OP_LOAD_B), 1'b0, '0);
         if ($urandom_range(0, 29) == 0) offer(make_compute_req(), 1'b0, '0);
      end
      repeat (EXTRA_LOADS) begin
         offer(make_load_req(OP_LOAD_A), 1'b0, '0);
         offer(make_compute_req(), 1'b0, '0);
      end
      item = '0;
      item.op = OP_PROD;
      item.total_length = '1;
      offer(item, 1'b0, '0);
      req_valid <= 1'b0;

      while (reduction_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d run loads, %0d of them dropped by a full store, and %0d reductions.",
               loads_seen, loads_dropped, reductions);
      $display("Of the reductions %0d clipped the accumulator and %0d ran out of runs.",
               sat_seen, exh_seen);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
